// File: rtl/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared widths, register indexes, codes and types of the touch gesture
// classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

	localparam int COORD_W = 16;
	localparam int COUNT_W = 4;
	localparam int TIME_W  = 32;
	localparam int ROT_W   = 2;
	localparam int DIR_W   = 2;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIME_MS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THRESHOLD = 3'd4;

	// reset values
	localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH    = 16'd320;
	localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT   = 16'd480;
	localparam logic [ROT_W-1:0]   RST_ROTATION        = 2'd0;
	localparam logic [CFG_W-1:0]   RST_PRESS_TIME_MS   = 16'd500;
	localparam logic [CFG_W-1:0]   RST_SWIPE_THRESHOLD = 16'd50;

	// rotation codes
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	// swipe direction codes
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] screen_width;
		logic [COORD_W-1:0] screen_height;
		logic [ROT_W-1:0]   rotation;
		logic [CFG_W-1:0]   press_time_ms;
		logic [CFG_W-1:0]   swipe_threshold;
	} cfg_t;

	typedef struct packed {
		logic               buffer_ready;
		logic [COUNT_W-1:0] touch_count;
		logic [COORD_W-1:0] raw_x;
		logic [COORD_W-1:0] raw_y;
		logic [TIME_W-1:0]  now_ms;
		logic               clear_flags;
	} poll_t;

	typedef struct packed {
		logic               holding;
		logic               long_press;
		logic               released;
		logic               swiped;
		logic [DIR_W-1:0]   swipe_dir;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
	} result_t;

endpackage

// File: rtl/tgc_if.sv
// ----------------------------------------------------------------------------
// tgc_if
// Valid/ready channels for controller polls and gesture results.
// ----------------------------------------------------------------------------
interface tgc_poll_if;
	logic                         valid;
	logic                         ready;
	logic                         buffer_ready;
	logic [tgc_pkg::COUNT_W-1:0]  touch_count;
	logic [tgc_pkg::COORD_W-1:0]  raw_x;
	logic [tgc_pkg::COORD_W-1:0]  raw_y;
	logic [tgc_pkg::TIME_W-1:0]   now_ms;
	logic                         clear_flags;

	modport source (output valid, buffer_ready, touch_count, raw_x, raw_y, now_ms,
		clear_flags, input ready);
	modport sink (input valid, buffer_ready, touch_count, raw_x, raw_y, now_ms,
		clear_flags, output ready);
endinterface

interface tgc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         holding;
	logic                         long_press;
	logic                         released;
	logic                         swiped;
	logic [tgc_pkg::DIR_W-1:0]    swipe_dir;
	logic [tgc_pkg::COORD_W-1:0]  point_x;
	logic [tgc_pkg::COORD_W-1:0]  point_y;

	modport source (output valid, holding, long_press, released, swiped, swipe_dir,
		point_x, point_y, input ready);
	modport sink (input valid, holding, long_press, released, swiped, swipe_dir,
		point_x, point_y, output ready);
endinterface

// File: rtl/tgc_rotate.sv
// ----------------------------------------------------------------------------
// tgc_rotate
// Maps a raw controller point into screen orientation, wrapping mod 2^16.
// ----------------------------------------------------------------------------
module tgc_rotate (
	input  logic [tgc_pkg::ROT_W-1:0]   rotation,
	input  logic [tgc_pkg::COORD_W-1:0] screen_width,
	input  logic [tgc_pkg::COORD_W-1:0] screen_height,
	input  logic [tgc_pkg::COORD_W-1:0] raw_x,
	input  logic [tgc_pkg::COORD_W-1:0] raw_y,
	output logic [tgc_pkg::COORD_W-1:0] x,
	output logic [tgc_pkg::COORD_W-1:0] y
);
	import tgc_pkg::*;

	logic [COORD_W-1:0] w_minus_x;
	logic [COORD_W-1:0] h_minus_y;

	assign w_minus_x = screen_width - raw_x;
	assign h_minus_y = screen_height - raw_y;

	always_comb begin
		unique case (rotation)
			ROT_90: begin
				x = h_minus_y;
				y = raw_x;
			end
			ROT_180: begin
				x = w_minus_x;
				y = h_minus_y;
			end
			ROT_270: begin
				x = raw_y;
				y = w_minus_x;
			end
			default: begin
				x = raw_x;
				y = raw_y;
			end
		endcase
	end

endmodule

// File: rtl/tgc_tracker.sv
// ----------------------------------------------------------------------------
// tgc_tracker
// Touch state, hold timer and press/release/swipe classification. Updates
// its state for one poll whenever step is high and presents that poll's result.
// ----------------------------------------------------------------------------
module tgc_tracker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  tgc_pkg::poll_t   poll,
	input  tgc_pkg::cfg_t    cfg,
	output tgc_pkg::result_t result
);
	import tgc_pkg::*;

	logic               touch_active_q, was_holding_q;
	logic               press_flag_q, release_flag_q, swipe_flag_q;
	logic [DIR_W-1:0]   swipe_code_q;
	logic [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [TIME_W-1:0]  hold_begin_q;

	logic               touch_active_d;
	logic               press_flag_d, release_flag_d, swipe_flag_d;
	logic [DIR_W-1:0]   swipe_code_d;
	logic [COORD_W-1:0] start_x_d, start_y_d, end_x_d, end_y_d;
	logic [TIME_W-1:0]  hold_begin_d;

	logic               holding;
	logic [COORD_W-1:0] rot_x, rot_y;
	logic [COORD_W-1:0] dx, dy;
	logic [TIME_W-1:0]  elapsed;

	tgc_rotate u_rotate (
		.rotation      (cfg.rotation),
		.screen_width  (cfg.screen_width),
		.screen_height (cfg.screen_height),
		.raw_x         (poll.raw_x),
		.raw_y         (poll.raw_y),
		.x             (rot_x),
		.y             (rot_y)
	);

	assign holding = poll.buffer_ready && (poll.touch_count != '0);
	assign dx = (start_x_q >= end_x_q) ? start_x_q - end_x_q : end_x_q - start_x_q;
	assign dy = (start_y_q >= end_y_q) ? start_y_q - end_y_q : end_y_q - start_y_q;
	assign elapsed = poll.now_ms - hold_begin_q;

	always_comb begin
		touch_active_d = touch_active_q;
		press_flag_d   = press_flag_q && !poll.clear_flags;
		release_flag_d = release_flag_q && !poll.clear_flags;
		swipe_flag_d   = swipe_flag_q && !poll.clear_flags;
		swipe_code_d   = swipe_code_q;
		start_x_d      = start_x_q;
		start_y_d      = start_y_q;
		end_x_d        = end_x_q;
		end_y_d        = end_y_q;
		hold_begin_d   = hold_begin_q;

		if (holding) begin
			if (!was_holding_q) begin
				start_x_d = rot_x;
				start_y_d = rot_y;
			end
			end_x_d = rot_x;
			end_y_d = rot_y;
		end

		if (!holding) begin
			// release: end point is the stored one, this poll moves nothing
			if (touch_active_q) begin
				touch_active_d = 1'b0;
				release_flag_d = 1'b1;
				if (dx > cfg.swipe_threshold || dy > cfg.swipe_threshold) begin
					swipe_flag_d = 1'b1;
					if (dx >= dy)
						swipe_code_d = (start_x_q > end_x_q) ? DIR_RIGHT : DIR_LEFT;
					else
						swipe_code_d = (start_y_q > end_y_q) ? DIR_DOWN : DIR_UP;
				end
			end
		end else if (touch_active_q) begin
			// long press ends the hold; next touching poll restarts the timer
			if (!press_flag_d && elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.press_time_ms}) begin
				touch_active_d = 1'b0;
				press_flag_d   = 1'b1;
			end
		end else begin
			touch_active_d = 1'b1;
			release_flag_d = 1'b0;
			hold_begin_d   = poll.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			was_holding_q  <= 1'b0;
			press_flag_q   <= 1'b0;
			release_flag_q <= 1'b0;
			swipe_flag_q   <= 1'b0;
			swipe_code_q   <= DIR_RIGHT;
			start_x_q      <= '0;
			start_y_q      <= '0;
			end_x_q        <= '0;
			end_y_q        <= '0;
			hold_begin_q   <= '0;
		end else if (step) begin
			touch_active_q <= touch_active_d;
			was_holding_q  <= holding;
			press_flag_q   <= press_flag_d;
			release_flag_q <= release_flag_d;
			swipe_flag_q   <= swipe_flag_d;
			swipe_code_q   <= swipe_code_d;
			start_x_q      <= start_x_d;
			start_y_q      <= start_y_d;
			end_x_q        <= end_x_d;
			end_y_q        <= end_y_d;
			hold_begin_q   <= hold_begin_d;
		end
	end

	assign result.holding    = holding;
	assign result.long_press = press_flag_d;
	assign result.released   = release_flag_d;
	assign result.swiped     = swipe_flag_d;
	assign result.swipe_dir  = swipe_code_d;
	assign result.point_x    = end_x_d;
	assign result.point_y    = end_y_d;

endmodule

// File: rtl/touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_core
// Press, long-press, release and swipe detection for a polled touch
// controller, with panel rotation of the reported point.
//
//   channel  dir  handshake      payload
//   poll     in   valid/ready    buffer_ready touch_count raw_x raw_y now_ms
//                                clear_flags
//   result   out  valid/ready    holding long_press released swiped swipe_dir
//                                point_x point_y
//   cfg      in   cfg_wr_en      cfg_index cfg_data, no read-back
//
// One poll per cycle sustained while result.ready stays high; a poll's result
// is presented once it has passed the input register, then the result register.
// The tracker state steps once per poll, as the poll leaves the input register.
// A stalled result holds in the result register while one more poll can wait
// in the input register; poll.ready drops only when both are full.
// Reset clears touch state, flags and loads the default configuration.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	tgc_poll_if.sink                      poll,
	tgc_result_if.source                  result,
	input  logic                          cfg_wr_en,
	input  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tgc_pkg::CFG_W-1:0]     cfg_data
);
	import tgc_pkg::*;

	cfg_t    cfg_q;
	poll_t   poll_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_next;
	logic    adv_s2;
	logic    step;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width    <= RST_SCREEN_WIDTH;
			cfg_q.screen_height   <= RST_SCREEN_HEIGHT;
			cfg_q.rotation        <= RST_ROTATION;
			cfg_q.press_time_ms   <= RST_PRESS_TIME_MS;
			cfg_q.swipe_threshold <= RST_SWIPE_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:    cfg_q.screen_width    <= cfg_data;
				CFG_SCREEN_HEIGHT:   cfg_q.screen_height   <= cfg_data;
				CFG_ROTATION:        cfg_q.rotation        <= cfg_data[ROT_W-1:0];
				CFG_PRESS_TIME_MS:   cfg_q.press_time_ms   <= cfg_data;
				CFG_SWIPE_THRESHOLD: cfg_q.swipe_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2     = !valid_s2 || result.ready;
	assign step       = valid_s1 && adv_s2;
	assign poll.ready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (poll.ready)
			valid_s1 <= poll.valid;
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			poll_s1.buffer_ready <= poll.buffer_ready;
			poll_s1.touch_count  <= poll.touch_count;
			poll_s1.raw_x        <= poll.raw_x;
			poll_s1.raw_y        <= poll.raw_y;
			poll_s1.now_ms       <= poll.now_ms;
			poll_s1.clear_flags  <= poll.clear_flags;
		end
	end

	tgc_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.poll   (poll_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_next;
	end

	assign result.valid      = valid_s2;
	assign result.holding    = res_s2.holding;
	assign result.long_press = res_s2.long_press;
	assign result.released   = res_s2.released;
	assign result.swiped     = res_s2.swiped;
	assign result.swipe_dir  = res_s2.swipe_dir;
	assign result.point_x    = res_s2.point_x;
	assign result.point_y    = res_s2.point_y;

endmodule

// File: tb/tb_touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_touch_gesture_classifier_core
// Drives controller polls through the gesture classifier and checks every
// result against a cycle-free tracker of touch state, flags and rotation.
// Runs a directed gesture sequence, then random gestures and noise under
// several panel settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_touch_gesture_classifier_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tgc_pkg::*;

	localparam int MAX_WAIT         = 18;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES     = 8;
	localparam int PHASE_ITEMS      = 230;

	typedef struct {
		bit                 active;
		bit                 was_holding;
		bit                 press;
		bit                 rel;
		bit                 swipe;
		logic [DIR_W-1:0]   dir;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [TIME_W-1:0]  hold_begin;
	} tracker_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tgc_poll_if   poll_bus();
	tgc_result_if result_bus();

	touch_gesture_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_bus),
		.result    (result_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cfg_t        panel_cfg;
	tracker_t    trk;
	poll_t       pending_polls[$];
	result_t     expected_results[$];
	poll_t       offered;
	int          tx_wait;
	int          rx_stall;
	int          long_hold_left;
	int          holds_asked;
	int          holds_served;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          queued_items;
	int          mismatch_count;
	int unsigned clock_ms;

	initial clk = 1'b0;

	always #5 clk = ~clk;

	// tracker: one poll in, one expected result out
	function automatic result_t track_poll(poll_t p);
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [TIME_W-1:0]  held;
		bit                 touching;
		result_t            r;
		touching = p.buffer_ready && (p.touch_count != 0);
		if (p.clear_flags) begin
			trk.press = 1'b0;
			trk.rel   = 1'b0;
			trk.swipe = 1'b0;
		end
		if (touching) begin
			x = p.raw_x;
			y = p.raw_y;
			case (panel_cfg.rotation)
				ROT_90: begin
					x = panel_cfg.screen_height - p.raw_y;
					y = p.raw_x;
				end
				ROT_180: begin
					x = panel_cfg.screen_width - p.raw_x;
					y = panel_cfg.screen_height - p.raw_y;
				end
				ROT_270: begin
					x = p.raw_y;
					y = panel_cfg.screen_width - p.raw_x;
				end
				default: ;
			endcase
			if (!trk.was_holding) begin
				trk.start_x = x;
				trk.start_y = y;
			end
			trk.end_x = x;
			trk.end_y = y;
		end
		trk.was_holding = touching;
		if (!touching) begin
			if (trk.active) begin
				dx = (trk.start_x >= trk.end_x) ? trk.start_x - trk.end_x
					: trk.end_x - trk.start_x;
				dy = (trk.start_y >= trk.end_y) ? trk.start_y - trk.end_y
					: trk.end_y - trk.start_y;
				trk.active = 1'b0;
				trk.rel    = 1'b1;
				if (dx > panel_cfg.swipe_threshold || dy > panel_cfg.swipe_threshold) begin
					trk.swipe = 1'b1;
					// equal travel goes to the x axis
					if (dx >= dy)
						trk.dir = (trk.start_x > trk.end_x) ? DIR_RIGHT : DIR_LEFT;
					else
						trk.dir = (trk.start_y > trk.end_y) ? DIR_DOWN : DIR_UP;
				end
			end
		end else if (trk.active) begin
			held = p.now_ms - trk.hold_begin;
			if (!trk.press && held > TIME_W'(panel_cfg.press_time_ms)) begin
				trk.active = 1'b0;
				trk.press  = 1'b1;
			end
		end else begin
			trk.active     = 1'b1;
			trk.rel        = 1'b0;
			trk.hold_begin = p.now_ms;
		end
		r.holding    = touching;
		r.long_press = trk.press;
		r.released   = trk.rel;
		r.swiped     = trk.swipe;
		r.swipe_dir  = trk.dir;
		r.point_x    = trk.end_x;
		r.point_y    = trk.end_y;
		return r;
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		mismatch_count++;
		$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			flag_mismatch("result with no poll pending", 0, 0);
			return;
		end
		want = expected_results.pop_front();
		if (result_bus.holding !== want.holding)
			flag_mismatch("holding", result_bus.holding, want.holding);
		if (result_bus.long_press !== want.long_press)
			flag_mismatch("long_press", result_bus.long_press, want.long_press);
		if (result_bus.released !== want.released)
			flag_mismatch("released", result_bus.released, want.released);
		if (result_bus.swiped !== want.swiped)
			flag_mismatch("swiped", result_bus.swiped, want.swiped);
		if (result_bus.swipe_dir !== want.swipe_dir)
			flag_mismatch("swipe_dir", result_bus.swipe_dir, want.swipe_dir);
		if (result_bus.point_x !== want.point_x)
			flag_mismatch("point_x", result_bus.point_x, want.point_x);
		if (result_bus.point_y !== want.point_y)
			flag_mismatch("point_y", result_bus.point_y, want.point_y);
	endtask

	// poll driver
	always @(posedge clk) begin : poll_driver
		poll_t nxt;
		if (!arst_n) begin
			poll_bus.valid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (poll_bus.valid && poll_bus.ready)
				expected_results.push_back(track_poll(offered));
			if (!poll_bus.valid || poll_bus.ready) begin
				if (tx_wait > 0) begin
					poll_bus.valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pending_polls.size() != 0) begin
					nxt = pending_polls.pop_front();
					offered <= nxt;
					poll_bus.buffer_ready <= nxt.buffer_ready;
					poll_bus.touch_count  <= nxt.touch_count;
					poll_bus.raw_x        <= nxt.raw_x;
					poll_bus.raw_y        <= nxt.raw_y;
					poll_bus.now_ms       <= nxt.now_ms;
					poll_bus.clear_flags  <= nxt.clear_flags;
					poll_bus.valid        <= 1'b1;
					tx_wait <= (tx_idle_on && $urandom_range(0, 1)) ? $urandom_range(0, MAX_WAIT) : 0;
				end else begin
					poll_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor, with random stalls and the long hold-off
	always @(posedge clk) begin : result_monitor
		int stall;
		int hold;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			rx_stall <= 0;
			long_hold_left <= 0;
		end else begin
			stall = rx_stall;
			hold  = long_hold_left;
			if (result_bus.valid && result_bus.ready) begin
				check_result();
				stall = (rx_idle_on && $urandom_range(0, 1)) ? $urandom_range(0, MAX_WAIT) : 0;
			end else if (stall > 0) begin
				stall--;
			end
			if (hold > 0) begin
				hold--;
			end else if (holds_served != holds_asked) begin
				hold = LONG_HOLD_CYCLES;
				holds_served = holds_served + 1;
			end
			rx_stall <= stall;
			long_hold_left <= hold;
			result_bus.ready <= (stall == 0) && (hold == 0);
		end
	end

	function automatic void push_poll(bit rdy, logic [COUNT_W-1:0] cnt,
		logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [TIME_W-1:0] now, bit clr);
		poll_t p;
		p.buffer_ready = rdy;
		p.touch_count  = cnt;
		p.raw_x        = x;
		p.raw_y        = y;
		p.now_ms       = now;
		p.clear_flags  = clr;
		pending_polls.push_back(p);
		queued_items++;
	endfunction

	function automatic void advance_clock();
		if ($urandom_range(0, 29) == 0)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(0, 120);
	endfunction

	function automatic void queue_no_touch();
		bit clr;
		clr = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 2))
			0: push_poll(1'b0, COUNT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
				clock_ms, clr);
			1: push_poll(1'b1, '0, COORD_W'($urandom), COORD_W'($urandom), clock_ms, clr);
			default: push_poll(1'b0, '0, COORD_W'($urandom), COORD_W'($urandom), clock_ms, clr);
		endcase
		advance_clock();
	endfunction

	// idle polls, a hold that wanders by up to span per poll, then a release
	function automatic void queue_gesture();
		int                 span;
		int                 step;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		repeat ($urandom_range(0, 3)) queue_no_touch();
		x = COORD_W'($urandom);
		y = COORD_W'($urandom);
		case ($urandom_range(0, 3))
			0: span = 0;
			1: span = 30;
			2: span = 400;
			default: span = 65535;
		endcase
		repeat ($urandom_range(1, 10)) begin
			push_poll(1'b1, COUNT_W'($urandom_range(1, 15)), x, y, clock_ms,
				$urandom_range(0, 15) == 0);
			step = $urandom_range(0, 2 * span);
			x = COORD_W'(x + step - span);
			step = $urandom_range(0, 2 * span);
			y = COORD_W'(y + step - span);
			advance_clock();
		end
		queue_no_touch();
	endfunction

	function automatic void queue_noise();
		push_poll(1'($urandom), COUNT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			$urandom, $urandom_range(0, 3) == 0);
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_polls.size() != 0 || poll_bus.valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
		logic [ROT_W-1:0] rot, logic [CFG_W-1:0] press_ms, logic [CFG_W-1:0] thr);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= CFG_ROTATION;
		cfg_data  <= CFG_W'(rot);
		@(posedge clk);
		cfg_index <= CFG_PRESS_TIME_MS;
		cfg_data  <= press_ms;
		@(posedge clk);
		cfg_index <= CFG_SWIPE_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		panel_cfg.screen_width    = w;
		panel_cfg.screen_height   = h;
		panel_cfg.rotation        = rot;
		panel_cfg.press_time_ms   = press_ms;
		panel_cfg.swipe_threshold = thr;
		@(negedge clk);
	endtask

	// two halves; the sender waits for every result between them
	task automatic run_phase(bit tx_idle, bit rx_idle, bit long_hold);
		int target;
		tx_idle_on = tx_idle;
		rx_idle_on = rx_idle;
		if (long_hold)
			holds_asked++;
		repeat (2) begin
			target = queued_items + PHASE_ITEMS / 2;
			while (queued_items < target) begin
				if ($urandom_range(0, 9) < 8)
					queue_gesture();
				else
					queue_noise();
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SCREEN_WIDTH;
		cfg_data  = '0;
		poll_bus.valid        = 1'b0;
		poll_bus.buffer_ready = 1'b0;
		poll_bus.touch_count  = '0;
		poll_bus.raw_x        = '0;
		poll_bus.raw_y        = '0;
		poll_bus.now_ms       = '0;
		poll_bus.clear_flags  = 1'b0;
		result_bus.ready      = 1'b0;
		tx_idle_on     = 1'b0;
		rx_idle_on     = 1'b0;
		holds_asked    = 0;
		holds_served   = 0;
		queued_items   = 0;
		mismatch_count = 0;
		clock_ms       = 0;
		trk = '{default: 0};
		panel_cfg.screen_width    = RST_SCREEN_WIDTH;
		panel_cfg.screen_height   = RST_SCREEN_HEIGHT;
		panel_cfg.rotation        = RST_ROTATION;
		panel_cfg.press_time_ms   = RST_PRESS_TIME_MS;
		panel_cfg.swipe_threshold = RST_SWIPE_THRESHOLD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, default settings
		push_poll(1'b0, 4'd5, 16'd7, 16'd7, 32'd1000, 1'b0);   // buffer not ready
		push_poll(1'b1, 4'd0, 16'd9, 16'd9, 32'd1000, 1'b0);   // zero touches
		push_poll(1'b1, 4'd1, 16'd100, 16'd100, 32'd1000, 1'b0);
		push_poll(1'b1, 4'd2, 16'd300, 16'd110, 32'd1100, 1'b0);
		push_poll(1'b0, 4'd0, 16'd0, 16'd0, 32'd1200, 1'b0);    // swipe left
		push_poll(1'b0, 4'd0, 16'd1234, 16'd4321, 32'd1300, 1'b0); // stale point, dir
		push_poll(1'b1, 4'd1, 16'd300, 16'd100, 32'd2000, 1'b0);
		push_poll(1'b1, 4'd1, 16'd300, 16'd100, 32'd2500, 1'b0); // exactly press time
		push_poll(1'b1, 4'd1, 16'd300, 16'd100, 32'd2501, 1'b0); // long press
		push_poll(1'b1, 4'd1, 16'd310, 16'd100, 32'd2600, 1'b0); // new hold, start kept
		push_poll(1'b0, 4'd0, 16'd0, 16'd0, 32'd2700, 1'b0);    // no swipe, flag sticks
		push_poll(1'b0, 4'd0, 16'd0, 16'd0, 32'd2800, 1'b1);    // clear while idle
		push_poll(1'b1, 4'd15, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0, 1'b0);
		push_poll(1'b1, 4'd1, 16'h0000, 16'hFFFF, 32'h0000_0100, 1'b0); // time wraps
		push_poll(1'b0, 4'd15, 16'd0, 16'd0, 32'h0000_0200, 1'b0); // tie, right
		push_poll(1'b1, 4'd1, 16'd200, 16'd0, 32'd5000, 1'b0);
		push_poll(1'b1, 4'd1, 16'd200, 16'd300, 32'd5100, 1'b0);
		push_poll(1'b0, 4'd0, 16'd0, 16'd0, 32'd5200, 1'b0);    // up
		push_poll(1'b1, 4'd1, 16'd200, 16'd300, 32'd6000, 1'b0);
		push_poll(1'b1, 4'd1, 16'd200, 16'd0, 32'd6100, 1'b1);  // clear while touching
		push_poll(1'b0, 4'd0, 16'd0, 16'd0, 32'd6200, 1'b0);    // down
		push_poll(1'b1, 4'd1, 16'd500, 16'd500, 32'd7000, 1'b0);
		push_poll(1'b1, 4'd1, 16'd550, 16'd500, 32'd7100, 1'b0);
		push_poll(1'b0, 4'd0, 16'd0, 16'd0, 32'd7200, 1'b0);    // travel equals threshold
		wait_drained();

		apply_config(16'd320, 16'd480, ROT_90, 16'd300, 16'd40);
		run_phase(1'b0, 1'b0, 1'b1);
		apply_config(16'd0, 16'd0, ROT_180, 16'd0, 16'd0);
		run_phase(1'b1, 1'b1, 1'b0);
		apply_config(16'hFFFF, 16'hFFFF, ROT_270, 16'hFFFF, 16'hFFFF);
		run_phase(1'b1, 1'b0, 1'b1);
		apply_config(16'd800, 16'd600, ROT_0, 16'd200, 16'd100);
		run_phase(1'b0, 1'b1, 1'b0);
		repeat (4) begin
			apply_config(COORD_W'($urandom), COORD_W'($urandom), ROT_W'($urandom),
				CFG_W'($urandom_range(0, 1000)), CFG_W'($urandom_range(0, 3000)));
			run_phase(1'($urandom), 1'($urandom), 1'($urandom));
		end

		if (mismatch_count == 0)
			$display("touch_gesture_classifier_core test passed");
		else
			$display("touch_gesture_classifier_core test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("touch_gesture_classifier_core test failed");
		$finish;
	end

endmodule
